### hw/rtl/grouping_char_list_store_defines.svh
// Assertion macros for the grouping character list store.
// Used by the top level only; no other dependencies.
`ifndef GROUPING_CHAR_LIST_STORE_DEFINES_SVH
`define GROUPING_CHAR_LIST_STORE_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset
`define GCLS_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off during reset
`define GCLS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### hw/rtl/gcls_pkg.sv
// Shared types and constants for the grouping character list store.
// No dependencies; imported by every module of the block.
package gcls_pkg;

	localparam int DEF_CAPACITY = 16;
	localparam int VALUE_W      = 8;
	localparam int POS_W        = 4;
	localparam int COUNT_OUT_W  = 5;

	typedef enum logic [1:0] {
		KIND_INSERT = 2'd0,
		KIND_DELETE = 2'd1,
		KIND_READ   = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		ST_DONE      = 2'd0,
		ST_NOT_FOUND = 2'd1,
		ST_FULL      = 2'd2,
		ST_BEYOND    = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_TAIL,
		S_RDW,
		S_DONE
	} state_t;

	// memory port strobes
	typedef struct packed {
		logic we;
		logic re;
	} mem_ctrl_t;

	// one result item
	typedef struct packed {
		status_t                  status;
		logic [COUNT_OUT_W-1:0]   entry_count;
		logic [VALUE_W-1:0]       read_value;
	} result_t;

endpackage

### hw/rtl/gcls_mem.sv
// Entry store: single-port-write, single-port-read synchronous RAM.
// Depends on gcls_pkg for the strobe struct and value width.
module gcls_mem #(
	parameter int DEPTH = gcls_pkg::DEF_CAPACITY,
	parameter int AW    = 4
) (
	input  logic                         clk,
	input  gcls_pkg::mem_ctrl_t          ctrl,
	input  logic [AW-1:0]                waddr,
	input  logic [gcls_pkg::VALUE_W-1:0] wdata,
	input  logic [AW-1:0]                raddr,
	output logic [gcls_pkg::VALUE_W-1:0] rdata
);
	import gcls_pkg::*;

	logic [VALUE_W-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (ctrl.we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (ctrl.re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

### hw/rtl/gcls_seq.sv
// Sequencer: walks the entry store once per insert or delete, shifting
// entries by read-modify-write; a read fetches a single entry. Depends on gcls_pkg.
module gcls_seq #(
	parameter int CAPACITY = gcls_pkg::DEF_CAPACITY,
	parameter int AW       = 4,
	parameter int CW       = 5
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [1:0]                   in_kind,
	input  logic [gcls_pkg::VALUE_W-1:0] in_value,
	input  logic [gcls_pkg::POS_W-1:0]   in_position,
	output logic                         res_valid,
	input  logic                         res_ready,
	output gcls_pkg::result_t            res,
	output logic [CW-1:0]                count,
	output gcls_pkg::mem_ctrl_t          mem_ctrl,
	output logic [AW-1:0]                mem_waddr,
	output logic [gcls_pkg::VALUE_W-1:0] mem_wdata,
	output logic [AW-1:0]                mem_raddr,
	input  logic [gcls_pkg::VALUE_W-1:0] mem_rdata
);
	import gcls_pkg::*;

	localparam int XW = CW + POS_W;

	state_t             state_q, state_d;
	kind_t              op_q;
	logic [VALUE_W-1:0] val_q;
	logic [VALUE_W-1:0] carry_q;
	logic [VALUE_W-1:0] rdval_q;
	status_t            status_q;
	logic [CW-1:0]      cnt_q;
	logic [CW-1:0]      rptr_q;
	logic [CW-1:0]      didx_s1;
	logic               found_q;

	kind_t              kind_in;
	logic               in_full, in_empty, in_beyond;
	logic [XW-1:0]      pos_ext, cnt_ext;
	logic [CW-1:0]      last_idx, prev_idx;
	logic               hit, at_last;
	logic [CW+COUNT_OUT_W-1:0] cnt_wide;

	assign kind_in   = kind_t'(in_kind);
	assign pos_ext   = {{CW{1'b0}}, in_position};
	assign cnt_ext   = {{POS_W{1'b0}}, cnt_q};
	assign in_full   = (cnt_q >= CW'(CAPACITY));
	assign in_empty  = (cnt_q == '0);
	assign in_beyond = (pos_ext >= cnt_ext) || (pos_ext >= XW'(CAPACITY));
	assign last_idx  = cnt_q - CW'(1);
	assign prev_idx  = didx_s1 - CW'(1);
	assign hit       = (mem_rdata == val_q);
	assign at_last   = (didx_s1 == last_idx);
	assign cnt_wide  = {{COUNT_OUT_W{1'b0}}, cnt_q};
	assign count     = cnt_q;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					case (kind_in)
						KIND_INSERT: state_d = in_full ? S_DONE : (in_empty ? S_TAIL : S_SCAN);
						KIND_DELETE: state_d = in_empty ? S_DONE : S_SCAN;
						KIND_READ:   state_d = in_beyond ? S_DONE : S_RDW;
						default:     state_d = S_DONE;
					endcase
				end
			end
			S_SCAN: begin
				if (at_last) begin
					state_d = (op_q == KIND_INSERT) ? S_TAIL : S_DONE;
				end
			end
			S_TAIL:  state_d = S_DONE;
			S_RDW:   state_d = S_DONE;
			S_DONE: begin
				if (res_ready) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// outputs and memory requests
	always_comb begin
		in_ready        = 1'b0;
		res_valid       = 1'b0;
		mem_ctrl        = '0;
		mem_waddr       = didx_s1[AW-1:0];
		mem_wdata       = carry_q;
		mem_raddr       = '0;
		res.status      = status_q;
		res.entry_count = cnt_wide[COUNT_OUT_W-1:0];
		res.read_value  = rdval_q;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					case (kind_in)
						KIND_INSERT, KIND_DELETE: begin
							mem_ctrl.re = !in_empty && !(kind_in == KIND_INSERT && in_full);
						end
						KIND_READ: begin
							mem_ctrl.re = !in_beyond;
							mem_raddr   = pos_ext[AW-1:0];
						end
						default: mem_ctrl.re = 1'b0;
					endcase
				end
			end
			S_SCAN: begin
				mem_ctrl.re = (rptr_q < cnt_q);
				mem_raddr   = rptr_q[AW-1:0];
				if (op_q == KIND_INSERT) begin
					// from the first match on, each entry moves one place down
					mem_ctrl.we = found_q || hit;
					mem_wdata   = found_q ? carry_q : val_q;
				end else begin
					// after the match, each entry moves one place up
					mem_ctrl.we = found_q;
					mem_waddr   = prev_idx[AW-1:0];
					mem_wdata   = mem_rdata;
				end
			end
			S_TAIL: begin
				mem_ctrl.we = 1'b1;
				mem_waddr   = cnt_q[AW-1:0];
				mem_wdata   = found_q ? carry_q : val_q;
			end
			S_RDW: begin
				mem_ctrl = '0;
			end
			S_DONE: begin
				res_valid = 1'b1;
			end
			default: begin
				mem_ctrl = '0;
			end
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
			found_q <= 1'b0;
		end else begin
			state_q <= state_d;
			unique case (state_q)
				S_IDLE: found_q <= 1'b0;
				S_SCAN: begin
					if (hit) begin
						found_q <= 1'b1;
					end
					if (at_last && op_q == KIND_DELETE && (found_q || hit)) begin
						cnt_q <= cnt_q - CW'(1);
					end
				end
				S_TAIL: cnt_q <= cnt_q + CW'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	// operation payload
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					op_q    <= kind_in;
					val_q   <= in_value;
					rptr_q  <= CW'(1);
					didx_s1 <= '0;
					rdval_q <= '0;
					case (kind_in)
						KIND_INSERT: status_q <= in_full ? ST_FULL : ST_DONE;
						KIND_DELETE: status_q <= in_empty ? ST_NOT_FOUND : ST_DONE;
						KIND_READ:   status_q <= in_beyond ? ST_BEYOND : ST_DONE;
						default:     status_q <= ST_DONE;
					endcase
				end
			end
			S_SCAN: begin
				rptr_q  <= rptr_q + CW'(1);
				didx_s1 <= didx_s1 + CW'(1);
				if (op_q == KIND_INSERT) begin
					if (found_q || hit) begin
						carry_q <= mem_rdata;
					end
				end else if (at_last) begin
					status_q <= (found_q || hit) ? ST_DONE : ST_NOT_FOUND;
				end
			end
			S_RDW: rdval_q <= mem_rdata;
			default: rdval_q <= rdval_q;
		endcase
	end

endmodule

### hw/rtl/grouping_char_list_store.sv
// Top level of the grouping character list store: sequencer, entry RAM and
// output register. Depends on gcls_pkg, gcls_mem, gcls_seq and the defines header.
//
// Ordered list of up to CAPACITY bytes held in one synchronous RAM. One item is
// handled at a time; each insert or delete takes one pass through the RAM, one
// entry per cycle, since the single read port sets the pace. An insert scans the
// list, then writes the tail entry (on an empty list it writes the tail at once),
// a delete scans the list, a read does one RAM read, and a refused, empty or
// unused-kind item goes straight to its result. A finished result waits in
// the output register, so the next item is taken while it is still unread.
// No clearing pass is needed after reset: only entries below the count are read.
`include "grouping_char_list_store_defines.svh"

module grouping_char_list_store #(
	parameter int CAPACITY = gcls_pkg::DEF_CAPACITY
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,  // [7:0] value, [11:8] position, [15:12] zero
	input  logic [1:0]  s_axis_tuser,  // [1:0] kind
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata,  // [4:0] entry_count, [12:5] read_value, [15:13] zero
	output logic [1:0]  m_axis_tuser   // [1:0] status
);
	import gcls_pkg::*;

	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW = $clog2(CAPACITY + 1);

	mem_ctrl_t          mem_ctrl;
	logic [AW-1:0]      mem_waddr, mem_raddr;
	logic [VALUE_W-1:0] mem_wdata, mem_rdata;
	logic               res_valid, res_ready;
	result_t            res;
	logic [CW-1:0]      count;
	logic               out_valid_q;
	result_t            out_q;

	gcls_mem #(
		.DEPTH (CAPACITY),
		.AW    (AW)
	) u_mem (
		.clk   (clk),
		.ctrl  (mem_ctrl),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	gcls_seq #(
		.CAPACITY (CAPACITY),
		.AW       (AW),
		.CW       (CW)
	) u_seq (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (s_axis_tvalid),
		.in_ready    (s_axis_tready),
		.in_kind     (s_axis_tuser),
		.in_value    (s_axis_tdata[7:0]),
		.in_position (s_axis_tdata[11:8]),
		.res_valid   (res_valid),
		.res_ready   (res_ready),
		.res         (res),
		.count       (count),
		.mem_ctrl    (mem_ctrl),
		.mem_waddr   (mem_waddr),
		.mem_wdata   (mem_wdata),
		.mem_raddr   (mem_raddr),
		.mem_rdata   (mem_rdata)
	);

	// output register: loads when empty or being drained
	assign res_ready = !out_valid_q || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res_valid) begin
			out_q <= res;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser  = out_q.status;
	assign m_axis_tdata  = {3'b000, out_q.read_value, out_q.entry_count};

	// checks
	`GCLS_ASSERT_NOW(a_count_bound, 1'b1, count <= CW'(CAPACITY), "entry count above capacity")
	`GCLS_ASSERT_NEXT(a_one_at_a_time, s_axis_tvalid && s_axis_tready, !s_axis_tready,
		"second item taken while one is in progress")
	`GCLS_ASSERT_NOW(a_rdval_done, m_axis_tvalid && (m_axis_tdata[12:5] != 8'd0),
		m_axis_tuser == ST_DONE, "read value present on a failed result")

endmodule

### bench/grouping_char_list_store_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for grouping_char_list_store: directed table, then random traffic.
// Depends on gcls_pkg and the block's RTL; needs no files or arguments.
module grouping_char_list_store_tb;
	import gcls_pkg::*;

	localparam int FILL_LIMIT   = DEF_CAPACITY;
	localparam int RANDOM_ITEMS = 900;
	localparam int DIR_ROWS     = 27;
	localparam int HOLD_AFTER   = 300;   // results seen before the long sink hold
	localparam int HOLD_CYCLES  = 400;
	localparam int PAUSE_AT     = 600;   // random item at which the source drains the block
	localparam int DRAIN_CYCLES = 40;    // idle wait after the last result, before the summary
	localparam logic [1:0] KIND_UNUSED = 2'd3;

	// one row of the directed table; typed rows carry their own expected result
	typedef struct packed {
		logic [1:0]         kind;
		logic [VALUE_W-1:0] value;
		logic [POS_W-1:0]   position;
		logic               typed;
		status_t            status;
		logic [4:0]         entry_count;
		logic [7:0]         read_value;
	} dir_row_t;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [15:0] s_axis_tdata;   // [7:0] value, [11:8] position, [15:12] zero
	logic [1:0]  s_axis_tuser;   // [1:0] kind
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [15:0] m_axis_tdata;   // [4:0] entry_count, [12:5] read_value, [15:13] zero
	logic [1:0]  m_axis_tuser;   // [1:0] status

	// shadow copy of the list, head first, and results still owed by the block
	logic [7:0] shadow_list[$];
	result_t    pending_results[$];

	int  mismatch_count;
	int  result_total;
	int  insert_total, delete_total, read_total, unused_total;
	int  full_total, not_found_total, beyond_total, peak_fill;
	logic sink_hold_done;

	dir_row_t dir_rows[DIR_ROWS];

	grouping_char_list_store #(
		.CAPACITY(FILL_LIMIT)
	) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser)
	);

	// 4 ns clock
	initial clk = 1'b0;
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// hard stop
	initial begin
		#4_000_000;
		$display("simulation failed");
		$finish;
	end

	task automatic report_mismatch(input string msg);
		$display("ERROR @%0t: %s", $realtime, msg);
		mismatch_count++;
	endtask

	// idle length: mostly short, now and then long
	function automatic int gap_length();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70)
			return $urandom_range(1, 3);
		else if (r < 95)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	// apply one operation to the shadow list and return the result it must give
	function automatic result_t list_apply(input logic [1:0] kind, input logic [7:0] value,
			input logic [3:0] position);
		result_t res;
		int      hit;
		res.status     = ST_DONE;
		res.read_value = '0;
		hit = shadow_list.size();
		for (int i = 0; i < shadow_list.size(); i++) begin
			if (shadow_list[i] == value) begin
				hit = i;
				break;
			end
		end
		case (kind)
			KIND_INSERT: begin
				insert_total++;
				if (shadow_list.size() >= FILL_LIMIT) begin
					res.status = ST_FULL;
					full_total++;
				end else begin
					// lands just before the first equal entry, or at the tail
					shadow_list.insert(hit, value);
				end
			end
			KIND_DELETE: begin
				delete_total++;
				if (hit >= shadow_list.size()) begin
					res.status = ST_NOT_FOUND;
					not_found_total++;
				end else begin
					shadow_list.delete(hit);
				end
			end
			KIND_READ: begin
				read_total++;
				if (position >= shadow_list.size()) begin
					res.status = ST_BEYOND;
					beyond_total++;
				end else begin
					res.read_value = shadow_list[position];
				end
			end
			default: unused_total++;
		endcase
		res.entry_count = 5'(shadow_list.size());
		if (shadow_list.size() > peak_fill)
			peak_fill = shadow_list.size();
		return res;
	endfunction

	// offer one item after an optional gap; predict once the transfer happens
	task automatic offer_item(input logic [1:0] kind, input logic [7:0] value,
			input logic [3:0] position, input int gap);
		if (gap > 0) begin
			@(negedge clk);
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		@(negedge clk);
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= kind;
		s_axis_tdata  <= {4'b0000, position, value};
		do
			@(posedge clk);
		while (!s_axis_tready);
		pending_results.push_back(list_apply(kind, value, position));
	endtask

	// sink side: random back-pressure, calm stretches, and one long hold
	initial begin : sink
		int stall_left;
		int calm_left;
		m_axis_tready = 1'b0;
		stall_left = 0;
		calm_left = 0;
		sink_hold_done = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (!sink_hold_done && result_total >= HOLD_AFTER) begin
				m_axis_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				sink_hold_done = 1'b1;
			end else if (stall_left > 0) begin
				m_axis_tready <= 1'b0;
				stall_left--;
			end else begin
				m_axis_tready <= 1'b1;
				if (calm_left > 0)
					calm_left--;
				else if ($urandom_range(0, 99) < 30)
					stall_left = gap_length();
				else if ($urandom_range(0, 99) < 5)
					calm_left = $urandom_range(20, 80);
			end
		end
	end

	// result checker
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			result_total++;
			if (pending_results.size() == 0) begin
				report_mismatch($sformatf("result %0d arrived with none pending", result_total));
			end else begin
				result_t want;
				want = pending_results.pop_front();
				if (m_axis_tuser != want.status)
					report_mismatch($sformatf("result %0d status: got %0d, expected %0d",
						result_total, m_axis_tuser, want.status));
				if (m_axis_tdata[4:0] != want.entry_count)
					report_mismatch($sformatf("result %0d entry_count: got %0d, expected %0d",
						result_total, m_axis_tdata[4:0], want.entry_count));
				if (m_axis_tdata[12:5] != want.read_value)
					report_mismatch($sformatf("result %0d read_value: got %0h, expected %0h",
						result_total, m_axis_tdata[12:5], want.read_value));
			end
		end
	end

	// source side and run control
	initial begin : source
		logic [7:0] value_pool[8];
		logic [1:0] kind;
		logic [7:0] value;
		logic [3:0] position;
		int         r;
		int         calm_left;
		int         gap;
		logic       growing;

		mismatch_count = 0;
		result_total = 0;
		insert_total = 0;
		delete_total = 0;
		read_total = 0;
		unused_total = 0;
		full_total = 0;
		not_found_total = 0;
		beyond_total = 0;
		peak_fill = 0;
		calm_left = 0;
		growing = 1'b1;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = '0;
		arst_n = 1'b0;

		// empty-list cases, extremes of value and position, grouping, then fill past capacity
		dir_rows = '{
			'{KIND_READ,   8'h00, 4'd0,  1'b1, ST_BEYOND,    5'd0,  8'h00},
			'{KIND_DELETE, 8'h00, 4'd0,  1'b1, ST_NOT_FOUND, 5'd0,  8'h00},
			'{KIND_UNUSED, 8'hFF, 4'd15, 1'b1, ST_DONE,      5'd0,  8'h00},
			'{KIND_INSERT, 8'h00, 4'd0,  1'b1, ST_DONE,      5'd1,  8'h00},
			'{KIND_INSERT, 8'hFF, 4'd15, 1'b1, ST_DONE,      5'd2,  8'h00},
			'{KIND_INSERT, 8'h00, 4'd0,  1'b0, ST_DONE,      5'd0,  8'h00},
			'{KIND_READ,   8'hFF, 4'd2,  1'b0, ST_DONE,      5'd0,  8'h00},
			'{KIND_DELETE, 8'h5A, 4'd0,  1'b1, ST_NOT_FOUND, 5'd3,  8'h00},
			'{KIND_READ,   8'h00, 4'd15, 1'b1, ST_BEYOND,    5'd3,  8'h00},
			'{KIND_DELETE, 8'hFF, 4'd5,  1'b0, ST_DONE,      5'd0,  8'h00},
			'{KIND_INSERT, 8'h01, 4'd0,  1'b0, ST_DONE,      5'd0,  8'h00},
			'{KIND_INSERT, 8'h80, 4'd0,  1'b0, ST_DONE,      5'd0,  8'h00},
			'{KIND_INSERT, 8'h7F, 4'd0,  1'b0, ST_DONE,      5'd0,  8'h00},
			'{KIND_INSERT, 8'hFE, 4'd0,  1'b0, ST_DONE,      5'd0,  8'h00},
			'{KIND_INSERT, 8'h55, 4'd0,  1'b0, ST_DONE,      5'd0,  8'h00},
			'{KIND_INSERT, 8'hAA, 4'd0,  1'b0, ST_DONE,      5'd0,  8'h00},
			'{KIND_INSERT, 8'h01, 4'd0,  1'b0, ST_DONE,      5'd0,  8'h00},
			'{KIND_INSERT, 8'h33, 4'd0,  1'b0, ST_DONE,      5'd0,  8'h00},
			'{KIND_INSERT, 8'hCC, 4'd0,  1'b0, ST_DONE,      5'd0,  8'h00},
			'{KIND_INSERT, 8'h80, 4'd0,  1'b0, ST_DONE,      5'd0,  8'h00},
			'{KIND_INSERT, 8'h0F, 4'd0,  1'b0, ST_DONE,      5'd0,  8'h00},
			'{KIND_INSERT, 8'hF0, 4'd0,  1'b0, ST_DONE,      5'd0,  8'h00},
			'{KIND_INSERT, 8'h55, 4'd0,  1'b0, ST_DONE,      5'd0,  8'h00},
			'{KIND_INSERT, 8'hFF, 4'd0,  1'b1, ST_DONE,      5'd16, 8'h00},
			'{KIND_INSERT, 8'h80, 4'd0,  1'b1, ST_FULL,      5'd16, 8'h00},
			'{KIND_READ,   8'h00, 4'd15, 1'b0, ST_DONE,      5'd0,  8'h00},
			'{KIND_DELETE, 8'h00, 4'd0,  1'b0, ST_DONE,      5'd0,  8'h00}
		};

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed table
		for (int i = 0; i < DIR_ROWS; i++) begin
			offer_item(dir_rows[i].kind, dir_rows[i].value, dir_rows[i].position,
				$urandom_range(0, 1) ? 0 : gap_length());
			if (dir_rows[i].typed)
				pending_results[pending_results.size() - 1] = '{dir_rows[i].status,
					dir_rows[i].entry_count, dir_rows[i].read_value};
		end

		// random traffic: values drawn mostly from a small pool so that they group and match
		foreach (value_pool[j])
			value_pool[j] = 8'($urandom_range(0, 255));
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			if (i == PAUSE_AT) begin
				@(negedge clk);
				s_axis_tvalid <= 1'b0;
				while (pending_results.size() != 0)
					@(posedge clk);
			end
			// swing between filling and draining so both ends are reached often
			if (shadow_list.size() >= FILL_LIMIT && $urandom_range(0, 3) == 0)
				growing = 1'b0;
			else if (shadow_list.size() == 0 && $urandom_range(0, 3) == 0)
				growing = 1'b1;
			else if ($urandom_range(0, 39) == 0)
				growing = !growing;
			if ($urandom_range(0, 49) == 0)
				value_pool[$urandom_range(0, 7)] = 8'($urandom_range(0, 255));

			value    = 8'($urandom_range(0, 255));
			position = 4'($urandom_range(0, 15));
			r = $urandom_range(0, 99);
			if (r < 3)
				kind = KIND_UNUSED;
			else if (r < (growing ? 58 : 28))
				kind = KIND_INSERT;
			else if (r < (growing ? 78 : 68))
				kind = KIND_DELETE;
			else
				kind = KIND_READ;

			case (kind)
				KIND_INSERT: begin
					if ($urandom_range(0, 9) < 7)
						value = value_pool[$urandom_range(0, 7)];
				end
				KIND_DELETE: begin
					if (shadow_list.size() != 0 && $urandom_range(0, 3) != 0)
						value = shadow_list[$urandom_range(0, shadow_list.size() - 1)];
					else if ($urandom_range(0, 1))
						value = value_pool[$urandom_range(0, 7)];
				end
				KIND_READ: begin
					if (shadow_list.size() != 0 && $urandom_range(0, 4) != 0)
						position = 4'($urandom_range(0, shadow_list.size() - 1));
				end
				default: ;
			endcase

			if (calm_left > 0) begin
				calm_left--;
				gap = 0;
			end else if ($urandom_range(0, 99) < 4) begin
				calm_left = $urandom_range(20, 80);
				gap = 0;
			end else begin
				gap = $urandom_range(0, 1) ? 0 : gap_length();
			end
			offer_item(kind, value, position, gap);
		end

		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("covered %0d inserts (%0d refused as full), %0d deletes (%0d not found),",
			insert_total, full_total, delete_total, not_found_total);
		$display("%0d reads (%0d beyond count), %0d unused kinds; peak fill %0d of %0d",
			read_total, beyond_total, unused_total, peak_fill, FILL_LIMIT);
		if (mismatch_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

### sim.f
+incdir+hw/rtl
hw/rtl/gcls_pkg.sv
hw/rtl/gcls_mem.sv
hw/rtl/gcls_seq.sv
hw/rtl/grouping_char_list_store.sv
bench/grouping_char_list_store_tb.sv
